// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define PEW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define PEW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/pew_pkg.sv -----
package pew_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 10;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int LINE_W     = 2 * PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(480);

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             last;
    logic [PIX_W-1:0] pixel;
  } pew_s1_t;

  typedef struct packed {
    logic [PIX_W-1:0] row_gradient;
    logic [PIX_W-1:0] column_gradient;
    logic [PIX_W-1:0] edge_strength;
    logic             frame_end;
  } pew_res_t;

endpackage

// ----- hw/rtl/pew_line_buf.sv -----
module pew_line_buf import pew_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [COL_W-1:0]  rd_addr_i,
  output logic [LINE_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [COL_W-1:0]  wr_addr_i,
  input  logic [LINE_W-1:0] wr_data_i,
  output logic              busy_o
);

  // one row per column: upper byte two lines above, lower byte one line above
  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_data_q;

  logic             clr_busy_q, clr_busy_d;
  logic [COL_W-1:0] clr_addr_q, clr_addr_d;

  logic              we;
  logic [COL_W-1:0]  waddr;
  logic [LINE_W-1:0] wdata;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + COL_W'(1);
      if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

// ----- hw/rtl/pew_grad.sv -----
module pew_grad import pew_pkg::*; (
  input  logic             clk_i,
  input  pew_s1_t          s1_i,
  input  logic [PIX_W-1:0] up1_i,
  input  logic [PIX_W-1:0] up2_i,
  output logic             push_o,
  output pew_res_t         res_o
);

  // window columns, index 0 is the top row
  logic [PIX_W-1:0] left_q [3];
  logic [PIX_W-1:0] mid_q  [3];

  logic [SUM_W-1:0] top, bot, lft, rgt;
  logic [PIX_W-1:0] rg, cg;
  logic [PIX_W:0]   es;

  function automatic logic [PIX_W-1:0] abs_clamp(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] m;
    m = (a >= b) ? (a - b) : (b - a);
    return (m > SUM_W'(PIX_MAX)) ? PIX_MAX : m[PIX_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (s1_i.valid) begin
      left_q[0] <= mid_q[0];
      left_q[1] <= mid_q[1];
      left_q[2] <= mid_q[2];
      mid_q[0]  <= up2_i;
      mid_q[1]  <= up1_i;
      mid_q[2]  <= s1_i.pixel;
    end
  end

  always_comb begin
    top = SUM_W'(left_q[0]) + SUM_W'(mid_q[0]) + SUM_W'(up2_i);
    bot = SUM_W'(left_q[2]) + SUM_W'(mid_q[2]) + SUM_W'(s1_i.pixel);
    lft = SUM_W'(left_q[0]) + SUM_W'(left_q[1]) + SUM_W'(left_q[2]);
    rgt = SUM_W'(up2_i) + SUM_W'(up1_i) + SUM_W'(s1_i.pixel);
    rg  = abs_clamp(bot, top);
    cg  = abs_clamp(rgt, lft);
    es  = {1'b0, rg} + {1'b0, cg};
  end

  assign push_o                = s1_i.valid & s1_i.emit;
  assign res_o.row_gradient    = rg;
  assign res_o.column_gradient = cg;
  assign res_o.edge_strength   = es[PIX_W] ? PIX_MAX : es[PIX_W-1:0];
  assign res_o.frame_end       = s1_i.last;

endmodule

// ----- hw/rtl/pew_out_fifo.sv -----
module pew_out_fifo import pew_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pew_res_t            data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output pew_res_t            data_o,
  output logic [OQ_CNT_W-1:0] count_o
);

  pew_res_t mem [OQ_DEPTH];

  logic [OQ_PTR_W-1:0] head_q, head_d;
  logic [OQ_PTR_W-1:0] tail_q, tail_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & ~stall_i;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      tail_d = tail_q + OQ_PTR_W'(1);
    end
    if (pop) begin
      head_d = head_q + OQ_PTR_W'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + OQ_CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= data_i;
    end
  end

  assign data_o  = mem[head_q];
  assign count_o = cnt_q;

endmodule

// ----- hw/rtl/prewitt_edge_magnitude.sv -----
// the word of a pixel that completes its window is formed from s1_q and pushed into the output queue
// throughput: one pixel per cycle unless stalled; one line read at accept, one write-back next cycle
// the output queue holds four words, so pixel_stall_o rises only on downstream stall or memory clear
// reset: width 640, height 480, counters zero, then a clear of the line memory
// during the clear pixel_stall_o is high; configuration writes are taken at any time
module prewitt_edge_magnitude import pew_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pixel_valid_i,
  output logic                  pixel_stall_o,
  input  logic [PIX_W-1:0]      pixel_i,
  output logic                  result_valid_o,
  input  logic                  result_stall_i,
  output logic [PIX_W-1:0]      row_gradient_o,
  output logic [PIX_W-1:0]      column_gradient_o,
  output logic [PIX_W-1:0]      edge_strength_o,
  output logic                  frame_end_o
);

  `include "assert_macros.svh"

  logic [WIDTH_W-1:0]  frame_width_q;
  logic [HEIGHT_W-1:0] frame_height_q;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_last;
  logic [ROW_W-1:0]    row_last;

  logic cfg_we;
  logic accept;
  logic busy;

  pew_s1_t          s1_q, s1_d;
  logic [COL_W-1:0] s1_col_q;

  logic [LINE_W-1:0]   rd_data;
  logic                push;
  pew_res_t            res;
  pew_res_t            out_word;
  logic [OQ_CNT_W-1:0] oq_cnt;
  logic [OQ_CNT_W-1:0] inflight;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RESET_WIDTH;
      frame_height_q <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // last column and row index of the clamped frame size
  always_comb begin
    if (frame_width_q < WIDTH_W'(3)) begin
      col_last = COL_W'(2);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(frame_width_q - WIDTH_W'(1));
    end
    if (frame_height_q < HEIGHT_W'(3)) begin
      row_last = ROW_W'(2);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(frame_height_q - HEIGHT_W'(1));
    end
  end

  assign inflight      = oq_cnt + OQ_CNT_W'(s1_q.valid);
  assign pixel_stall_o = busy | (32'(inflight) >= OQ_DEPTH);
  assign accept        = pixel_valid_i & ~pixel_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we && (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT)) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == col_last) begin
        col_d = '0;
        row_d = (row_q == row_last) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_d.valid = accept;
    s1_d.emit  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    s1_d.last  = (row_q == row_last) && (col_q == col_last);
    s1_d.pixel = pixel_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s1_q  <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_q.valid <= s1_d.valid;
      s1_q.emit  <= s1_d.emit;
      s1_q.last  <= s1_d.last;
      if (accept) begin
        s1_q.pixel <= s1_d.pixel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q <= col_q;
    end
  end

  // within a frame the same column comes back only after at least three pixels, so no forwarding
  pew_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_q.valid),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({rd_data[PIX_W-1:0], s1_q.pixel}),
    .busy_o    (busy)
  );

  pew_grad u_grad (
    .clk_i  (clk_i),
    .s1_i   (s1_q),
    .up1_i  (rd_data[PIX_W-1:0]),
    .up2_i  (rd_data[LINE_W-1:PIX_W]),
    .push_o (push),
    .res_o  (res)
  );

  pew_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .valid_o (result_valid_o),
    .stall_i (result_stall_i),
    .data_o  (out_word),
    .count_o (oq_cnt)
  );

  assign row_gradient_o    = out_word.row_gradient;
  assign column_gradient_o = out_word.column_gradient;
  assign edge_strength_o   = out_word.edge_strength;
  assign frame_end_o       = out_word.frame_end;

  `PEW_ASSERT(a_oq_no_overflow, clk_i, rst_ni, push |-> (32'(oq_cnt) < OQ_DEPTH), "output queue overflow")
  `PEW_ASSERT(a_no_rw_collision, clk_i, rst_ni, (accept && s1_q.valid) |-> (col_q != s1_col_q), "line memory read hits pending write-back")
  `PEW_ASSERT(a_no_work_in_clear, clk_i, rst_ni, busy |-> (!s1_q.valid && !accept), "pixel in flight during line memory clear")
  `PEW_ASSERT(a_emit_on_interior, clk_i, rst_ni, accept && row_q < ROW_W'(2) |=> !push, "result from a border row")

endmodule

// ----- bench/prewitt_edge_magnitude_tb.sv -----
module prewitt_edge_magnitude_tb;
  import pew_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 260;
  localparam int MAX_GAP       = 12;

  // row edge, column edge, and both edges at once
  localparam logic [PIX_W-1:0] DIRECTED_PIXELS [27] = '{
    8'd255, 8'd255, 8'd255,  8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0,
    8'd255, 8'd0,   8'd0,    8'd255, 8'd0,   8'd0,   8'd255, 8'd0, 8'd0,
    8'd0,   8'd0,   8'd50,   8'd0,   8'd255, 8'd50,  8'd60, 8'd60, 8'd110
  };

  typedef enum int {TEXTURE_UNIFORM, TEXTURE_BINARY, TEXTURE_SMOOTH} texture_e;

  class edge_scoreboard;
    logic [PIX_W-1:0]    line_mem [2*MAX_WIDTH];
    logic [PIX_W-1:0]    win [9];
    int unsigned         col;
    int unsigned         row;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    pew_res_t            pending_edges [$];
    int                  mismatches;
    int                  edges_checked;
    int                  pixels_taken;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      mismatches = 0;
      edges_checked = 0;
      pixels_taken = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = data[WIDTH_W-1:0];
          col = 0;
          row = 0;
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data[HEIGHT_W-1:0];
          col = 0;
          row = 0;
        end
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] sat_abs(int d);
      int m;
      m = (d < 0) ? -d : d;
      return (m > int'(PIX_MAX)) ? PIX_MAX : PIX_W'(m);
    endfunction

    function void take_pixel(logic [PIX_W-1:0] px);
      int unsigned w, h, c, r;
      logic [PIX_W-1:0] above1, above2;
      int top, bot, lft, rgt, sum;
      pew_res_t e;
      w = width_reg;
      h = height_reg;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 3) h = 3;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      c = (col >= w) ? 0 : col;
      r = (row >= h) ? 0 : row;
      above1 = line_mem[c];
      above2 = line_mem[MAX_WIDTH + c];
      line_mem[MAX_WIDTH + c] = above1;
      line_mem[c] = px;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3 + 1];
        win[k*3+1] = win[k*3 + 2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = px;
      if (r >= 2 && c >= 2) begin
        top = int'(win[0]) + int'(win[1]) + int'(win[2]);
        bot = int'(win[6]) + int'(win[7]) + int'(win[8]);
        lft = int'(win[0]) + int'(win[3]) + int'(win[6]);
        rgt = int'(win[2]) + int'(win[5]) + int'(win[8]);
        e.row_gradient = sat_abs(bot - top);
        e.column_gradient = sat_abs(rgt - lft);
        sum = int'(e.row_gradient) + int'(e.column_gradient);
        e.edge_strength = (sum > int'(PIX_MAX)) ? PIX_MAX : PIX_W'(sum);
        e.frame_end = (r == h - 1) && (c == w - 1);
        pending_edges.push_back(e);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col = c;
      row = r;
      pixels_taken++;
    endfunction

    function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] seen);
      if (seen !== want) begin
        $display("%0t: word %0d %s expected %0d actual %0d",
                 $time, edges_checked, name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_edge(logic [PIX_W-1:0] rg, logic [PIX_W-1:0] cg,
                             logic [PIX_W-1:0] es, logic fe);
      pew_res_t want;
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected word rg=%0d cg=%0d es=%0d fe=%0d, expected none",
                 $time, rg, cg, es, fe);
        mismatches++;
        return;
      end
      want = pending_edges.pop_front();
      compare_field("row_gradient", want.row_gradient, rg);
      compare_field("column_gradient", want.column_gradient, cg);
      compare_field("edge_strength", want.edge_strength, es);
      compare_field("frame_end", PIX_W'(want.frame_end), PIX_W'(fe));
      edges_checked++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  pixel_valid_i;
  logic                  pixel_stall_o;
  logic [PIX_W-1:0]      pixel_i;
  logic                  result_valid_o;
  logic                  result_stall_i;
  logic [PIX_W-1:0]      row_gradient_o;
  logic [PIX_W-1:0]      column_gradient_o;
  logic [PIX_W-1:0]      edge_strength_o;
  logic                  frame_end_o;

  edge_scoreboard sb;
  int unsigned    cycles = 0;
  int             result_hold = 0;
  bit             result_quiet = 1'b0;
  bit             pixel_quiet = 1'b0;
  int             smooth_level = 128;
  int             reg_writes = 0;

  prewitt_edge_magnitude u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pixel_valid_i     (pixel_valid_i),
    .pixel_stall_o     (pixel_stall_o),
    .pixel_i           (pixel_i),
    .result_valid_o    (result_valid_o),
    .result_stall_i    (result_stall_i),
    .row_gradient_o    (row_gradient_o),
    .column_gradient_o (column_gradient_o),
    .edge_strength_o   (edge_strength_o),
    .frame_end_o       (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, sb.pending_edges.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall after each word, with quiet stretches
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && !result_stall_i) begin
      sb.check_edge(row_gradient_o, column_gradient_o, edge_strength_o, frame_end_o);
      result_hold = result_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 49) == 0) result_quiet = !result_quiet;
    end else if (result_hold > 0) begin
      result_hold--;
    end
    result_stall_i <= (result_hold != 0);
  end

  function automatic logic [PIX_W-1:0] draw_pixel(texture_e tex);
    case (tex)
      TEXTURE_BINARY: return $urandom_range(0, 1) ? PIX_MAX : '0;
      TEXTURE_SMOOTH: begin
        smooth_level = smooth_level + int'($urandom_range(0, 16)) - 8;
        if (smooth_level < 0) smooth_level = 0;
        if (smooth_level > int'(PIX_MAX)) smooth_level = int'(PIX_MAX);
        return PIX_W'(smooth_level);
      end
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] value);
    int gap;
    gap = pixel_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 59) == 0) pixel_quiet = !pixel_quiet;
    if (gap > 0) begin
      pixel_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i <= value;
    do @(posedge clk_i); while (pixel_stall_o);
    sb.take_pixel(value);
  endtask

  task automatic send_pixels(int count, texture_e tex);
    repeat (count) send_pixel(draw_pixel(tex));
  endtask

  // stop sending, wait for every expected word, then let the pipeline empty
  task automatic drain();
    pixel_valid_i <= 1'b0;
    while (sb.pending_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata,
                           bit with_unknown);
    write_reg(REG_FRAME_WIDTH, wdata);
    if (with_unknown)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_FRAME_HEIGHT) + 1, 2**CFG_IDX_W - 1)),
                CFG_DATA_W'($urandom));
    write_reg(REG_FRAME_HEIGHT, hdata);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int w, h, weff, heff, count, pick, random_pixels;
    logic [CFG_DATA_W-1:0] wdata, hdata;
    texture_e tex;
    sb = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    pixel_valid_i = 1'b0;
    pixel_i = '0;
    result_stall_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry, stopped a little way into the third line
    send_pixels(2 * int'(RESET_WIDTH) + 20, TEXTURE_UNIFORM);
    drain();

    set_frame(CFG_DATA_W'(3), CFG_DATA_W'(3), 1'b0);
    foreach (DIRECTED_PIXELS[i]) send_pixel(DIRECTED_PIXELS[i]);
    drain();

    // out-of-range width, maximum height and out-of-range height
    set_frame('1, CFG_DATA_W'(3), 1'b1);
    send_pixels(40, TEXTURE_BINARY);
    drain();
    set_frame(CFG_DATA_W'(3), CFG_DATA_W'(MAX_HEIGHT), 1'b0);
    send_pixels(40, TEXTURE_SMOOTH);
    drain();
    set_frame(CFG_DATA_W'(3), '1, 1'b0);
    send_pixels(40, TEXTURE_UNIFORM);
    drain();

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 9);
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
      h = $urandom_range(3, 8);
      if (pick == 0) w = $urandom_range(0, 2);
      if (pick == 1) h = $urandom_range(0, 2);
      wdata = CFG_DATA_W'(w);
      hdata = CFG_DATA_W'(h);
      // bits above the width field are dropped
      if (pick == 2) wdata = wdata | (CFG_DATA_W'($urandom_range(1, 3)) << WIDTH_W);
      if (pick == 3) hdata = CFG_DATA_W'($urandom_range(MAX_HEIGHT + 1, 2**HEIGHT_W - 1));
      weff = (w < 3) ? 3 : w;
      heff = (pick == 3) ? MAX_HEIGHT : ((h < 3) ? 3 : h);
      if (pick == 3)
        count = weff * $urandom_range(3, 10);
      else if (weff * heff > 200)
        count = weff * heff + $urandom_range(0, weff * heff - 1);
      else
        count = weff * heff * $urandom_range(1, 3) + $urandom_range(0, weff * heff - 1);
      if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
      tex = texture_e'($urandom_range(0, 2));
      set_frame(wdata, hdata, $urandom_range(0, 4) == 0);
      send_pixels(count, tex);
      random_pixels += count;
      drain();
    end

    $display("streamed %0d pixels through %0d register writes: start of a reset-size frame,",
             sb.pixels_taken, reg_writes);
    $display("3x3 edge patterns, clamped sizes, random small frames; %0d words, %0d mismatches",
             sb.edges_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_edges.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pew_pkg.sv
hw/rtl/pew_line_buf.sv
hw/rtl/pew_grad.sv
hw/rtl/pew_out_fifo.sv
hw/rtl/prewitt_edge_magnitude.sv
bench/prewitt_edge_magnitude_tb.sv
